/* rtl/core/pva_pkg.sv */
// Package for the polyphonic voice allocator.
// Holds the sequencer state type, the fixed note range and the port word widths.
// No dependencies.
`default_nettype none

package pva_pkg;

    localparam int NOTES           = 128;
    localparam int NOTE_W          = 7;
    localparam int VEL_W           = 7;
    localparam int DEF_VOICES      = 4;
    localparam int DEF_STAMP_WIDTH = 32;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 16;
    localparam int MASK_W          = 4;
    localparam int VIDX_W          = 2;

    localparam logic OP_NOTE_ON  = 1'b0;
    localparam logic OP_NOTE_OFF = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SREAD,
        ST_SCMP,
        ST_OREAD,
        ST_OCHK,
        ST_OFF_CHK,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/poly_voice_allocator.sv */
// Polyphonic voice allocator, top level and only module.
// Keeps per-note owner and press-stamp memories, voice state in flops.
// Depends on pva_pkg.
//
// One event is taken at a time. A note-off passes through decode, then an
// owner check when the note is owned, then emit. A note-on passes through
// decode, the owner read and check, and emit; when every voice is gated the
// stamp memory is read once per voice through its single read port before
// the owner read. The next event is accepted while an earlier result still
// waits on the output register. The owner valid bits and stamp valid bits
// are flops cleared by reset, so no clearing pass is needed.
`default_nettype none

module poly_voice_allocator #(
    parameter int VOICES      = pva_pkg::DEF_VOICES,
    parameter int STAMP_WIDTH = pva_pkg::DEF_STAMP_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [6:0] note_number, [13:7] velocity, [15:14] zero
    input  wire logic [pva_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [3:0] gate_mask, [7:4] active_mask, [8] any_gate, [10:9] voice_index,
    // [11] voice_touched, [15:12] zero
    output logic [pva_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import pva_pkg::*;

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MW = (VOICES > MASK_W) ? VOICES : MASK_W;
    localparam int XW = (IW > VIDX_W) ? IW : VIDX_W;
    localparam int AW = $clog2(NOTES);

    t_state r_state, n_state;

    logic                   r_op;
    logic [NOTE_W-1:0]      r_note;
    logic [VEL_W-1:0]       r_vel;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          r_cnt;
    logic [STAMP_WIDTH-1:0] r_best;
    logic [STAMP_WIDTH-1:0] r_press;
    logic                   r_touched;

    logic [VOICES-1:0]      r_active;
    logic [VOICES-1:0]      r_gate;
    logic [NOTE_W-1:0]      r_vnote [VOICES];

    logic [NOTES-1:0]       r_own_vld;
    logic [NOTES-1:0]       r_stamp_vld;
    logic [IW-1:0]          own_mem [NOTES];
    logic [STAMP_WIDTH-1:0] stamp_mem [NOTES];
    logic [IW-1:0]          r_own_q;
    logic [STAMP_WIDTH-1:0] r_stamp_q;
    logic                   r_stamp_q_vld;

    logic                   r_m_valid;
    logic [M_TDATA_W-1:0]   r_m_data;

    logic                   note_on;
    logic                   s_fire;
    logic                   out_load;
    logic [AW-1:0]          own_raddr;
    logic [AW-1:0]          stamp_raddr;
    logic                   found;
    logic [IW-1:0]          pick;
    logic [STAMP_WIDTH-1:0] scan_stamp;
    logic                   scan_take;
    logic [NOTE_W-1:0]      prev_note;
    logic                   own_clear;
    logic [MW-1:0]          gate_ext;
    logic [MW-1:0]          active_ext;
    logic [XW-1:0]          idx_ext;
    logic [M_TDATA_W-1:0]   result;

    assign note_on   = (r_op == OP_NOTE_ON) && (r_vel != '0);
    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign out_load  = (r_state == ST_EMIT) && (!r_m_valid || m_axis_tready);
    assign prev_note = r_vnote[r_idx];

    // First never-used voice, else first ungated voice.
    always_comb begin
        logic hit_free;
        logic hit_open;
        logic [IW-1:0] p_free;
        logic [IW-1:0] p_open;
        hit_free = 1'b0;
        hit_open = 1'b0;
        p_free   = '0;
        p_open   = '0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!r_gate[v] && !r_active[v]) begin
                hit_free = 1'b1;
                p_free   = IW'(v);
            end
            if (!r_gate[v]) begin
                hit_open = 1'b1;
                p_open   = IW'(v);
            end
        end
        found = hit_free || hit_open;
        pick  = hit_free ? p_free : p_open;
    end

    assign scan_stamp = r_stamp_q_vld ? r_stamp_q : '0;
    assign scan_take  = (r_cnt == '0) || (scan_stamp < r_best);
    assign own_clear  = r_active[r_idx] && r_own_vld[prev_note[AW-1:0]] && (r_own_q == r_idx);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_fire) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (note_on) begin
                    n_state = found ? ST_OREAD : ST_SREAD;
                end else if (r_own_vld[r_note[AW-1:0]]) begin
                    n_state = ST_OFF_CHK;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SREAD:   n_state = ST_SCMP;
            ST_SCMP: begin
                n_state = (r_cnt == IW'(VOICES - 1)) ? ST_OREAD : ST_SREAD;
            end
            ST_OREAD:   n_state = ST_OCHK;
            ST_OCHK:    n_state = ST_EMIT;
            ST_OFF_CHK: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        own_raddr     = r_note[AW-1:0];
        stamp_raddr   = r_vnote[r_cnt][AW-1:0];
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_OREAD: own_raddr     = prev_note[AW-1:0];
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Memories: registered read every cycle, single write port each.
    always_ff @(posedge i_clk) begin
        r_own_q   <= own_mem[own_raddr];
        r_stamp_q <= stamp_mem[stamp_raddr];
        if (r_state == ST_OCHK) begin
            own_mem[r_note[AW-1:0]] <= r_idx;
        end
        if (r_state == ST_DECODE && note_on) begin
            stamp_mem[r_note[AW-1:0]] <= r_press + STAMP_WIDTH'(1);
        end
    end

    // Input capture and scan datapath
    always_ff @(posedge i_clk) begin
        r_stamp_q_vld <= r_stamp_vld[stamp_raddr];
        if (s_fire) begin
            r_op   <= s_axis_tuser;
            r_note <= s_axis_tdata[NOTE_W-1:0];
            r_vel  <= s_axis_tdata[NOTE_W +: VEL_W];
        end
        case (r_state)
            ST_DECODE: begin
                r_idx <= note_on ? pick : '0;
                r_cnt <= '0;
            end
            ST_SCMP: begin
                if (scan_take) begin
                    r_best <= scan_stamp;
                    r_idx  <= r_cnt;
                end
                r_cnt <= r_cnt + IW'(1);
            end
            ST_OFF_CHK: r_idx <= r_own_q;
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
        if (r_state == ST_OCHK) begin
            r_vnote[r_idx] <= r_note;
        end
    end

    // Control state: voices, valid bits, press counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_gate      <= '0;
            r_own_vld   <= '0;
            r_stamp_vld <= '0;
            r_press     <= '0;
            r_touched   <= 1'b0;
        end else begin
            case (r_state)
                ST_DECODE: begin
                    r_touched <= 1'b0;
                    if (note_on) begin
                        r_press                       <= r_press + STAMP_WIDTH'(1);
                        r_stamp_vld[r_note[AW-1:0]]   <= 1'b1;
                    end
                end
                ST_OCHK: begin
                    if (own_clear && (prev_note != r_note)) begin
                        r_own_vld[prev_note[AW-1:0]] <= 1'b0;
                    end
                    r_own_vld[r_note[AW-1:0]] <= 1'b1;
                    r_active[r_idx]           <= 1'b1;
                    r_gate[r_idx]             <= 1'b1;
                    r_touched                 <= 1'b1;
                end
                ST_OFF_CHK: begin
                    r_own_vld[r_note[AW-1:0]] <= 1'b0;
                    r_gate[r_own_q]           <= 1'b0;
                    r_touched                 <= 1'b1;
                end
                default: begin
                    r_touched <= r_touched;
                end
            endcase
        end
    end

    assign gate_ext   = MW'(r_gate);
    assign active_ext = MW'(r_active);
    assign idx_ext    = XW'(r_idx);

    always_comb begin
        result                           = '0;
        result[MASK_W-1:0]               = gate_ext[MASK_W-1:0];
        result[2*MASK_W-1:MASK_W]        = active_ext[MASK_W-1:0];
        result[2*MASK_W]                 = |r_gate;
        result[2*MASK_W+1 +: VIDX_W]     = idx_ext[VIDX_W-1:0];
        result[2*MASK_W+1+VIDX_W]        = r_touched;
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (out_load) begin
            r_m_data <= result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

/* bench/tb_poly_voice_allocator.sv */
`timescale 1ns / 100ps
// Testbench for poly_voice_allocator: directed and random note-on/note-off words,
// each output word checked against a voice allocation predictor held here.
// Depends on pva_pkg and the allocator RTL.

module tb_poly_voice_allocator;
    import pva_pkg::*;

    localparam int N_VOICES = DEF_VOICES;

    typedef struct packed {
        logic [MASK_W-1:0] gate_mask;
        logic [MASK_W-1:0] active_mask;
        logic              any_gate;
        logic [VIDX_W-1:0] voice_index;
        logic              voice_touched;
    } t_voice_status;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    t_voice_status status_due[$];
    t_voice_status status_want;
    int            mismatches    = 0;
    int            src_idle_pct  = 0;
    int            snk_stall_pct = 0;

    bit                       voice_active[N_VOICES];
    bit                       voice_gate[N_VOICES];
    bit [NOTE_W-1:0]          voice_note[N_VOICES];
    bit                       note_owned[NOTES];
    int                       note_voice[NOTES];
    bit [DEF_STAMP_WIDTH-1:0] note_stamp[NOTES];
    bit [DEF_STAMP_WIDTH-1:0] press_count;

    poly_voice_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    function automatic int pick_voice();
        int best;
        best = 0;
        for (int v = 0; v < N_VOICES; v++)
            if (!voice_gate[v] && !voice_active[v]) return v;
        for (int v = 0; v < N_VOICES; v++)
            if (!voice_gate[v]) return v;
        for (int v = 1; v < N_VOICES; v++)
            if (note_stamp[voice_note[v]] < note_stamp[voice_note[best]]) best = v;
        return best;
    endfunction

    function automatic void allocate_or_release(logic op, logic [NOTE_W-1:0] note,
                                                logic [VEL_W-1:0] vel);
        t_voice_status st;
        int            vi;
        st = '0;
        vi = 0;
        if (op == OP_NOTE_ON && vel != 0) begin
            press_count      = press_count + DEF_STAMP_WIDTH'(1);
            note_stamp[note] = press_count;
            vi               = pick_voice();
            if (voice_active[vi] && note_owned[voice_note[vi]]
                && note_voice[voice_note[vi]] == vi)
                note_owned[voice_note[vi]] = 1'b0;
            voice_active[vi] = 1'b1;
            voice_gate[vi]   = 1'b1;
            voice_note[vi]   = note;
            note_owned[note] = 1'b1;
            note_voice[note] = vi;
            st.voice_touched = 1'b1;
        end else if (note_owned[note]) begin
            vi               = note_voice[note];
            note_owned[note] = 1'b0;
            voice_gate[vi]   = 1'b0;
            st.voice_touched = 1'b1;
        end
        for (int v = 0; v < N_VOICES; v++) begin
            st.gate_mask[v]   = voice_gate[v];
            st.active_mask[v] = voice_active[v];
        end
        st.any_gate    = |st.gate_mask;
        st.voice_index = vi[VIDX_W-1:0];
        status_due.push_back(st);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_due.size() == 0) begin
                report_mismatch("unexpected word", int'(m_axis_tdata), 0);
            end else begin
                status_want = status_due.pop_front();
                if (m_axis_tdata[3:0] !== status_want.gate_mask)
                    report_mismatch("gate_mask", int'(m_axis_tdata[3:0]),
                                    int'(status_want.gate_mask));
                if (m_axis_tdata[7:4] !== status_want.active_mask)
                    report_mismatch("active_mask", int'(m_axis_tdata[7:4]),
                                    int'(status_want.active_mask));
                if (m_axis_tdata[8] !== status_want.any_gate)
                    report_mismatch("any_gate", int'(m_axis_tdata[8]),
                                    int'(status_want.any_gate));
                if (m_axis_tdata[10:9] !== status_want.voice_index)
                    report_mismatch("voice_index", int'(m_axis_tdata[10:9]),
                                    int'(status_want.voice_index));
                if (m_axis_tdata[11] !== status_want.voice_touched)
                    report_mismatch("voice_touched", int'(m_axis_tdata[11]),
                                    int'(status_want.voice_touched));
            end
        end
    end

    task automatic send_event(input logic op, input logic [NOTE_W-1:0] note,
                              input logic [VEL_W-1:0] vel);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, vel, note};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        allocate_or_release(op, note, vel);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (status_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_voices();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_event(OP_NOTE_ON, 7'd0, 7'd127);
        send_event(OP_NOTE_ON, 7'd127, 7'd1);
        send_event(OP_NOTE_ON, 7'd64, 7'd64);
        send_event(OP_NOTE_ON, 7'd85, 7'd42);
        // steal oldest
        send_event(OP_NOTE_ON, 7'd42, 7'd85);
        send_event(OP_NOTE_OFF, 7'd0, 7'd0);
        send_event(OP_NOTE_OFF, 7'd127, 7'd127);
        send_event(OP_NOTE_ON, 7'd64, 7'd0);
        // repeat a held note: old voice stays gated with no owner
        send_event(OP_NOTE_ON, 7'd85, 7'd100);
        send_event(OP_NOTE_ON, 7'd10, 7'd7);
        send_event(OP_NOTE_ON, 7'd11, 7'd120);
        // tie on stamps
        send_event(OP_NOTE_ON, 7'd12, 7'd3);
        send_event(OP_NOTE_ON, 7'd13, 7'd9);
        send_event(OP_NOTE_OFF, 7'd85, 7'd1);
        send_event(OP_NOTE_OFF, 7'd99, 7'd0);
        send_event(OP_NOTE_OFF, 7'd11, 7'd33);
        send_event(OP_NOTE_OFF, 7'd12, 7'd66);
        send_event(OP_NOTE_ON, 7'd13, 7'd0);
        send_event(OP_NOTE_OFF, 7'd10, 7'd127);
        send_event(OP_NOTE_ON, 7'd127, 7'd127);
        send_event(OP_NOTE_ON, 7'd0, 7'd1);
        hold_until_drained();
    endtask

    task automatic test_random_traffic(input int count, input int idle, input int stall);
        int               roll;
        int               pool_base;
        logic             op;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        pool_base     = $urandom_range(0, NOTES - 8);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 39) begin
                hold_until_drained();
                pool_base = $urandom_range(0, NOTES - 8);
            end
            roll = $urandom_range(0, 99);
            note = NOTE_W'(pool_base + $urandom_range(0, 7));
            if (roll >= 88) note = NOTE_W'($urandom_range(0, NOTES - 1));
            if (roll < 50) begin
                op  = OP_NOTE_ON;
                vel = (roll < 4) ? '0 : VEL_W'($urandom_range(1, 127));
            end else begin
                op  = OP_NOTE_OFF;
                vel = VEL_W'($urandom_range(0, 127));
            end
            send_event(op, note, vel);
        end
        hold_until_drained();
    endtask

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_voices();
        test_random_traffic(100, 0, 0);
        test_random_traffic(100, 54, 0);
        test_random_traffic(100, 0, 54);
        test_random_traffic(100, 33, 33);
        repeat (24) @(posedge i_clk);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
